// File: rtl/dtks_pkg.sv
// dtks_pkg: constants, tables and helper functions for the DES trial-decrypt key search.
// Standalone package; used by des_trial_decrypt_key_search and its checker.
package dtks_pkg;

  localparam int unsigned IDX_W = 39;
  localparam int unsigned BLK_W = 64;

  // 28^8, the size of the key space
  localparam logic [IDX_W-1:0] KEYSPACE = 39'd377801998336;
  // floor(2^31 / 2401), 2401 * 256 = 28^4
  localparam logic [19:0] RECIP_2401 = 20'd894412;
  localparam logic [11:0] DIV_2401 = 12'd2401;
  // floor(2^20 / 28)
  localparam logic [15:0] RECIP_28 = 16'd37449;
  localparam logic [5:0] DIV_28 = 6'd28;

  localparam logic [7:0] UC_LO = 8'd65;
  localparam logic [7:0] UC_HI = 8'd90;
  localparam logic [7:0] LC_LO = 8'd97;
  localparam logic [7:0] LC_HI = 8'd122;

  localparam logic [7:0] ALPHA_T [28] = '{
    8'h41, 8'h42, 8'h44, 8'h46, 8'h48, 8'h4A, 8'h4C, 8'h4E, 8'h50, 8'h52, 8'h54, 8'h56,
    8'h58, 8'h5A, 8'h61, 8'h62, 8'h64, 8'h66, 8'h68, 8'h6A, 8'h6C, 8'h6E, 8'h70, 8'h72,
    8'h74, 8'h76, 8'h78, 8'h7A};

  localparam logic [6:0] IP_T [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2, 7'd60, 7'd52, 7'd44, 7'd36,
    7'd28, 7'd20, 7'd12, 7'd4, 7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8, 7'd57, 7'd49, 7'd41, 7'd33,
    7'd25, 7'd17, 7'd9, 7'd1, 7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5, 7'd63, 7'd55, 7'd47, 7'd39,
    7'd31, 7'd23, 7'd15, 7'd7};

  localparam logic [6:0] FP_T [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32, 7'd39, 7'd7, 7'd47, 7'd15,
    7'd55, 7'd23, 7'd63, 7'd31, 7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29, 7'd36, 7'd4, 7'd44, 7'd12,
    7'd52, 7'd20, 7'd60, 7'd28, 7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26, 7'd33, 7'd1, 7'd41, 7'd9,
    7'd49, 7'd17, 7'd57, 7'd25};

  localparam logic [5:0] E_T [48] = '{
    6'd32, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9,
    6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

  localparam logic [5:0] P_T [32] = '{
    6'd16, 6'd7, 6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17, 6'd1, 6'd15, 6'd23, 6'd26,
    6'd5, 6'd18, 6'd31, 6'd10, 6'd2, 6'd8, 6'd24, 6'd14, 6'd32, 6'd27, 6'd3, 6'd9,
    6'd19, 6'd13, 6'd30, 6'd6, 6'd22, 6'd11, 6'd4, 6'd25};

  localparam logic [6:0] PC1_T [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9, 7'd1, 7'd58, 7'd50, 7'd42, 7'd34,
    7'd26, 7'd18, 7'd10, 7'd2, 7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6, 7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5, 7'd28, 7'd20, 7'd12, 7'd4};

  localparam logic [5:0] PC2_T [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1, 6'd5, 6'd3, 6'd28, 6'd15, 6'd6, 6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4, 6'd26, 6'd8, 6'd16, 6'd7, 6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

  // key schedule rotation per round in encrypt order; 1 means one place, 0 two
  localparam logic ROT1_T [16] = '{
    1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

  localparam logic [3:0] SBOX_T [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd15,4'd14,4'd2,4'd3,4'd12,4'd0},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  typedef struct packed {
    logic [19:0] quo;
    logic [4:0]  rem;
  } div28_t;

  // x / 28 for x < 2^20: reciprocal estimate is exact or one low
  function automatic div28_t div28(input logic [19:0] x);
    logic [35:0] pr;
    logic [15:0] q;
    logic [19:0] t;
    div28_t      res;
    pr = x * RECIP_28;
    q  = pr[35:20];
    t  = x - 20'(q) * 20'(DIV_28);
    if (t[5:0] >= DIV_28) begin
      res.quo = 20'(q) + 20'd1;
      res.rem = 5'(t[5:0] - DIV_28);
    end else begin
      res.quo = 20'(q);
      res.rem = t[4:0];
    end
    return res;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= UC_LO) && (b <= UC_HI)) || ((b >= LC_LO) && (b <= LC_HI));
  endfunction

  function automatic logic all_letters(input logic [63:0] d);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 8; i++) ok = ok & is_letter(d[8*i +: 8]);
    return ok;
  endfunction

  function automatic logic [63:0] des_ip(input logic [63:0] d);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) o[63-i] = d[6'(64 - int'(IP_T[i]))];
    return o;
  endfunction

  function automatic logic [63:0] des_fp(input logic [63:0] d);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) o[63-i] = d[6'(64 - int'(FP_T[i]))];
    return o;
  endfunction

  function automatic logic [55:0] des_pc1(input logic [63:0] k);
    logic [55:0] o;
    for (int i = 0; i < 56; i++) o[55-i] = k[6'(64 - int'(PC1_T[i]))];
    return o;
  endfunction

  function automatic logic [47:0] des_pc2(input logic [55:0] cd);
    logic [47:0] o;
    for (int i = 0; i < 48; i++) o[47-i] = cd[6'(56 - int'(PC2_T[i]))];
    return o;
  endfunction

  // right rotation of both 28-bit halves (decrypt order key schedule)
  function automatic logic [55:0] cd_rotr(input logic [55:0] cd, input logic one);
    logic [27:0] c;
    logic [27:0] d;
    c = cd[55:28];
    d = cd[27:0];
    if (one) return {c[0], c[27:1], d[0], d[27:1]};
    return {c[1:0], c[27:2], d[1:0], d[27:2]};
  endfunction

  function automatic logic [31:0] des_f(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [5:0]  b;
    logic [31:0] o;
    for (int i = 0; i < 48; i++) x[47-i] = r[5'(32 - int'(E_T[i]))];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[6*(7-i) +: 6];
      s[4*(7-i) +: 4] = SBOX_T[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) o[31-i] = s[5'(32 - int'(P_T[i]))];
    return o;
  endfunction

endpackage

// File: rtl/des_trial_decrypt_key_search.sv
// Throughput: one candidate per cycle; a stalled output freezes the whole pipeline.
// Front end: 3 stages reduce the index and split it in two base-28^4 halves (one
// 31x20 multiply), 4 stages peel one digit from each half, 16 stages run one DES
// round each, one stage applies FP and the letter check. Reset (rst_n low, sync)
// clears all valid bits and the ciphertext register.
module des_trial_decrypt_key_search
  import dtks_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // candidate channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [IDX_W-1:0]    in_candidate_index,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BLK_W-1:0]    out_candidate_key,
  output logic [BLK_W-1:0]    out_decrypted_block,
  output logic                out_all_letters,
  output logic [IDX_W-1:0]    out_index_echo,
  // ciphertext register write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BLK_W-1:0]    cfg_ciphertext_block
);

  // Whole pipeline moves together unless the output register holds a stalled result.
  logic adv;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // ciphertext register; to be written only while the pipeline is empty, which the block itself does not enforce
  logic [BLK_W-1:0] ct_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ct_r <= '0;
    end else if (cfg_valid) begin
      ct_r <= cfg_ciphertext_block;
    end
  end

  // ---- stage 0: fold the index into the key space (index < 2 * 28^8) ----
  logic             v0_r;
  logic [IDX_W-1:0] idx0_r, n0_r, n0_nxt;
  assign n0_nxt = (in_candidate_index >= KEYSPACE) ? in_candidate_index - KEYSPACE
                                                   : in_candidate_index;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      idx0_r <= in_candidate_index;
      n0_r   <= n0_nxt;
    end
  end

  // ---- stage 1: n / 28^4 = (n >> 8) / 2401, reciprocal product ----
  logic             v1_r;
  logic [IDX_W-1:0] idx1_r;
  logic [30:0]      x1_r;
  logic [7:0]       lo1_r;
  logic [50:0]      prod1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      idx1_r  <= idx0_r;
      x1_r    <= n0_r[38:8];
      lo1_r   <= n0_r[7:0];
      prod1_r <= n0_r[38:8] * RECIP_2401;
    end
  end

  // ---- stage 2: correct the estimate; a = top four digits, b = low four ----
  logic             v2_r;
  logic [IDX_W-1:0] idx2_r;
  logic [19:0]      a2_r, b2_r, a2_nxt, b2_nxt;
  logic [19:0]      q2;
  logic [30:0]      t2;
  always_comb begin
    q2 = prod1_r[50:31];
    t2 = x1_r - 31'(q2) * 31'(DIV_2401);
    if (t2[12:0] >= 13'(DIV_2401)) begin
      a2_nxt = q2 + 20'd1;
      b2_nxt = {12'(t2[12:0] - 13'(DIV_2401)), lo1_r};
    end else begin
      a2_nxt = q2;
      b2_nxt = {t2[11:0], lo1_r};
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      idx2_r <= idx1_r;
      a2_r   <= a2_nxt;
      b2_r   <= b2_nxt;
    end
  end

  // ---- stages 3..6: one base-28 digit from each half per stage, least first ----
  logic             dv_r   [4];
  logic [IDX_W-1:0] didx_r [4];
  logic [19:0]      da_r   [4];
  logic [19:0]      db_r   [4];
  logic [BLK_W-1:0] dkey_r [4];

  for (genvar j = 0; j < 4; j++) begin : g_digit
    logic             v_in;
    logic [IDX_W-1:0] idx_in;
    logic [19:0]      a_in, b_in;
    logic [BLK_W-1:0] key_in, key_nxt;
    div28_t           da, db;

    if (j == 0) begin : g_first
      assign v_in   = v2_r;
      assign idx_in = idx2_r;
      assign a_in   = a2_r;
      assign b_in   = b2_r;
      assign key_in = '0;
    end else begin : g_next
      assign v_in   = dv_r[j-1];
      assign idx_in = didx_r[j-1];
      assign a_in   = da_r[j-1];
      assign b_in   = db_r[j-1];
      assign key_in = dkey_r[j-1];
    end

    always_comb begin
      da      = div28(a_in);
      db      = div28(b_in);
      key_nxt = key_in;
      // high half digit j lands in key byte 3-j, low half digit j in byte 7-j
      key_nxt[8*(4+j) +: 8] = ALPHA_T[da.rem];
      key_nxt[8*j +: 8]     = ALPHA_T[db.rem];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (adv) begin
        dv_r[j] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        didx_r[j] <= idx_in;
        da_r[j]   <= da.quo;
        db_r[j]   <= db.quo;
        dkey_r[j] <= key_nxt;
      end
    end
  end

  // ---- stages 7..22: one DES decrypt round each ----
  // Key schedule runs backward: first round uses PC2 of PC1(key) itself,
  // then right-rotates by the encrypt-order amount of the round it undoes.
  logic             rv_r   [16];
  logic [IDX_W-1:0] ridx_r [16];
  logic [BLK_W-1:0] rkey_r [16];
  logic [55:0]      rcd_r  [16];
  logic [31:0]      rl_r   [16];
  logic [31:0]      rr_r   [16];

  for (genvar k = 0; k < 16; k++) begin : g_round
    logic             v_in;
    logic [IDX_W-1:0] idx_in;
    logic [BLK_W-1:0] key_in;
    logic [55:0]      cd_in;
    logic [31:0]      l_in, r_in;

    if (k == 0) begin : g_first
      logic [63:0] ipb;
      assign ipb    = des_ip(ct_r);
      assign v_in   = dv_r[3];
      assign idx_in = didx_r[3];
      assign key_in = dkey_r[3];
      assign cd_in  = des_pc1(dkey_r[3]);
      assign l_in   = ipb[63:32];
      assign r_in   = ipb[31:0];
    end else begin : g_next
      assign v_in   = rv_r[k-1];
      assign idx_in = ridx_r[k-1];
      assign key_in = rkey_r[k-1];
      assign cd_in  = rcd_r[k-1];
      assign l_in   = rl_r[k-1];
      assign r_in   = rr_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[k] <= 1'b0;
      end else if (adv) begin
        rv_r[k] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ridx_r[k] <= idx_in;
        rkey_r[k] <= key_in;
        rcd_r[k]  <= cd_rotr(cd_in, ROT1_T[15-k]);
        rl_r[k]   <= r_in;
        rr_r[k]   <= l_in ^ des_f(r_in, des_pc2(cd_in));
      end
    end
  end

  // ---- stage 23: swap halves, final permutation, letter check ----
  logic [63:0] plain_nxt;
  assign plain_nxt = des_fp({rr_r[15], rl_r[15]});

  logic             ov_r;
  logic [BLK_W-1:0] okey_r, oplain_r;
  logic             olet_r;
  logic [IDX_W-1:0] oidx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= rv_r[15];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      okey_r   <= rkey_r[15];
      oplain_r <= plain_nxt;
      olet_r   <= all_letters(plain_nxt);
      oidx_r   <= ridx_r[15];
    end
  end

  assign out_valid           = ov_r;
  assign out_candidate_key   = okey_r;
  assign out_decrypted_block = oplain_r;
  assign out_all_letters     = olet_r;
  assign out_index_echo      = oidx_r;

endmodule

// File: rtl/dtks_checker.sv
// dtks_checker: port-level assertions for des_trial_decrypt_key_search, plus its bind.
// Depends on dtks_pkg.
module dtks_checker
  import dtks_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [BLK_W-1:0] out_candidate_key,
  input logic [BLK_W-1:0] out_decrypted_block,
  input logic             out_all_letters,
  input logic [IDX_W-1:0] out_index_echo
);

  // reset empties the result channel
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the input side only stalls when a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled without output backpressure");

  // a held result keeps its decrypted block and index echo
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_decrypted_block)
      && $stable(out_index_echo))
    else $error("stalled result changed");

  // flag agrees with the plaintext shown
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_all_letters == all_letters(out_decrypted_block))
    else $error("letter flag mismatch");

  // every key byte comes from the letter alphabet
  a_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> all_letters(out_candidate_key))
    else $error("key byte outside alphabet");

endmodule

bind des_trial_decrypt_key_search dtks_checker u_dtks_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_candidate_key   (out_candidate_key),
  .out_decrypted_block (out_decrypted_block),
  .out_all_letters     (out_all_letters),
  .out_index_echo      (out_index_echo)
);
